// ===== src/jsu_pkg.sv =====
// Shared types and constants for the 3x3 Jacobi solver unit.
package jsu_pkg;

   localparam int SWEEPS = 12;
   localparam int SWEEP_W = $clog2(SWEEPS + 1);
   localparam int Q_W = 32;
   localparam int NUM_W = 48;
   localparam int DIV_STEPS = 4;
   localparam int DIV_CYC = NUM_W / DIV_STEPS;
   localparam int DCNT_W = $clog2(DIV_CYC + 1);

   localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_MUL,
      LANE_SUM,
      LANE_DIV,
      LANE_FIN
   } lane_state_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_SWEEP,
      TOP_DONE
   } top_state_type;

   typedef struct packed {
      logic start;
      logic signed [Q_W-1:0] rhs;
      logic signed [Q_W-1:0] c1;
      logic signed [Q_W-1:0] e1;
      logic signed [Q_W-1:0] c2;
      logic signed [Q_W-1:0] e2;
      logic signed [Q_W-1:0] diag;
   } lane_in_type;

   typedef struct packed {
      logic done;
      logic sat;
      logic signed [Q_W-1:0] value;
   } lane_out_type;

endpackage

// ===== src/jacobi_3x3_linear_solver_unit.sv =====
// Top level of the 3x3 Jacobi solver unit: sweep control, three lanes, result merge.
//
// The req_ channel takes one item per system: twelve signed Q16.16 coefficients
// in req_tdata, row by row, each row as x, y, z coefficient and right-hand side.
// The rsp_ channel returns one item per system with x, y and z in rsp_tdata and
// the zero-diagonal and saturation flags in rsp_tuser.
// Three lanes, one per unknown, compute a sweep side by side; each lane forms two
// products, a saturating sum and a quotient from a divider that retires four
// quotient bits per cycle. Each item runs twelve sweeps, and a new item is taken
// only after the previous solve has finished its sweeps.
// An item with a zero diagonal skips the sweeps and goes straight to the done state.
// A new item can be taken once the previous result has entered the output
// register, while that result may still wait there.
// When the receiver stalls, the finished result holds in the output register and
// the next solve waits for it to be taken before loading its own result.
// Synchronous reset empties the output register and returns control to idle.
module jacobi_3x3_linear_solver_unit import jsu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: row1_x_coef, row1_y_coef, row1_z_coef, row1_rhs,
   // row2_x_coef, row2_y_coef, row2_z_coef, row2_rhs,
   // row3_x_coef, row3_y_coef, row3_z_coef, row3_rhs.
   input  logic [383:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: x_value, y_value, z_value.
   output logic [95:0]  rsp_tdata,
   // Fields from bit 0: zero_diagonal, saturated.
   output logic [1:0]   rsp_tuser
);

   top_state_type state_ff, state_in;
   logic [383:0] coef_ff, coef_in;
   logic signed [Q_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic sat_ff, sat_in, zd_ff, zd_in, start_ff, start_in;
   logic [SWEEP_W-1:0] sweep_ff, sweep_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_user_ff, rsp_user_in;

   logic signed [Q_W-1:0] c [12];
   lane_in_type lx_in, ly_in, lz_in;
   lane_out_type lx_out, ly_out, lz_out;
   logic zero_diag;

   always_comb begin
      for (int i = 0; i < 12; i++) begin
         c[i] = coef_ff[i*Q_W +: Q_W];
      end
   end

   assign zero_diag = (req_tdata[31:0] == '0) || (req_tdata[191:160] == '0)
                      || (req_tdata[351:320] == '0);

   assign lx_in = '{start: start_ff, rhs: c[3], c1: c[1], e1: y_ff,
                    c2: c[2], e2: z_ff, diag: c[0]};
   assign ly_in = '{start: start_ff, rhs: c[7], c1: c[4], e1: x_ff,
                    c2: c[6], e2: z_ff, diag: c[5]};
   assign lz_in = '{start: start_ff, rhs: c[11], c1: c[8], e1: x_ff,
                    c2: c[9], e2: y_ff, diag: c[10]};

   jsu_lane u_lane_x (.clock(clock), .reset(reset), .lane_in(lx_in), .lane_out(lx_out));
   jsu_lane u_lane_y (.clock(clock), .reset(reset), .lane_in(ly_in), .lane_out(ly_out));
   jsu_lane u_lane_z (.clock(clock), .reset(reset), .lane_in(lz_in), .lane_out(lz_out));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TOP_IDLE;
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      coef_ff <= coef_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      sat_ff <= sat_in;
      zd_ff <= zd_in;
      sweep_ff <= sweep_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      state_in = state_ff;
      coef_in = coef_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      sat_in = sat_ff;
      zd_in = zd_ff;
      sweep_in = sweep_ff;
      start_in = 1'b0;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready = 1'b0;
      unique case (state_ff)
         TOP_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               coef_in = req_tdata;
               x_in = '0;
               y_in = '0;
               z_in = '0;
               sat_in = 1'b0;
               zd_in = zero_diag;
               sweep_in = '0;
               if (zero_diag) begin
                  state_in = TOP_DONE;
               end else begin
                  start_in = 1'b1;
                  state_in = TOP_SWEEP;
               end
            end
         end
         TOP_SWEEP: begin
            if (lx_out.done) begin
               x_in = lx_out.value;
               y_in = ly_out.value;
               z_in = lz_out.value;
               sat_in = sat_ff | lx_out.sat | ly_out.sat | lz_out.sat;
               sweep_in = sweep_ff + 1'b1;
               if (sweep_ff == SWEEP_W'(SWEEPS - 1)) begin
                  state_in = TOP_DONE;
               end else begin
                  start_in = 1'b1;
               end
            end
         end
         TOP_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {z_ff, y_ff, x_ff};
               rsp_user_in = {sat_ff, zd_ff};
               state_in = TOP_IDLE;
            end
         end
         default: state_in = TOP_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// ===== src/jsu_lane.sv =====
// One update lane: two products, saturating sum and an iterative divider.
module jsu_lane import jsu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  lane_in_type  lane_in,
   output lane_out_type lane_out
);

   lane_state_type state_ff, state_in;
   logic signed [63:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [NUM_W-1:0] num_ff, num_in, quot_ff, quot_in;
   logic [Q_W-1:0] rem_ff, rem_in, dmag_ff, dmag_in;
   logic neg_ff, neg_in, sat_ff, sat_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic signed [Q_W-1:0] val_ff, val_in;
   logic done_ff, done_in;

   logic signed [63:0] f1, f2;
   logic signed [Q_W-1:0] q1, q2, s32;
   logic signed [Q_W+1:0] s;
   logic [Q_W:0] trial;
   logic [Q_W-1:0] r;
   logic [NUM_W-1:0] n, qt;
   logic [Q_W-1:0] smag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LANE_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      num_ff <= num_in;
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff <= neg_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      val_ff <= val_in;
   end

   always_comb begin
      state_in = state_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      num_in = num_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      dmag_in = dmag_ff;
      neg_in = neg_ff;
      sat_in = sat_ff;
      cnt_in = cnt_ff;
      val_in = val_ff;
      done_in = 1'b0;
      f1 = p1_ff >>> 16;
      f2 = p2_ff >>> 16;
      q1 = f1[Q_W-1:0];
      q2 = f2[Q_W-1:0];
      s = '0;
      s32 = '0;
      smag = '0;
      r = rem_ff;
      n = num_ff;
      qt = quot_ff;
      trial = '0;
      unique case (state_ff)
         LANE_IDLE: begin
            if (lane_in.start) begin
               p1_in = lane_in.c1 * lane_in.e1;
               p2_in = lane_in.c2 * lane_in.e2;
               dmag_in = lane_in.diag[Q_W-1] ? Q_W'(-lane_in.diag) : lane_in.diag;
               sat_in = 1'b0;
               state_in = LANE_MUL;
            end
         end
         LANE_MUL: begin
            if (f1 > 64'(Q_MAX)) begin
               q1 = Q_MAX;
               sat_in = 1'b1;
            end else if (f1 < 64'(Q_MIN)) begin
               q1 = Q_MIN;
               sat_in = 1'b1;
            end
            if (f2 > 64'(Q_MAX)) begin
               q2 = Q_MAX;
               sat_in = 1'b1;
            end else if (f2 < 64'(Q_MIN)) begin
               q2 = Q_MIN;
               sat_in = 1'b1;
            end
            s = (Q_W+2)'(lane_in.rhs) - (Q_W+2)'(q1) - (Q_W+2)'(q2);
            s32 = s[Q_W-1:0];
            if (s > (Q_W+2)'(Q_MAX)) begin
               s32 = Q_MAX;
               sat_in = 1'b1;
            end else if (s < (Q_W+2)'(Q_MIN)) begin
               s32 = Q_MIN;
               sat_in = 1'b1;
            end
            smag = s32[Q_W-1] ? Q_W'(-s32) : s32;
            num_in = {smag, 16'b0};
            neg_in = s32[Q_W-1] ^ lane_in.diag[Q_W-1];
            state_in = LANE_SUM;
         end
         LANE_SUM: begin
            rem_in = '0;
            quot_in = '0;
            cnt_in = '0;
            state_in = LANE_DIV;
         end
         LANE_DIV: begin
            for (int k = 0; k < DIV_STEPS; k++) begin
               trial = {r, n[NUM_W-1]};
               n = {n[NUM_W-2:0], 1'b0};
               if (trial >= {1'b0, dmag_ff}) begin
                  trial = trial - {1'b0, dmag_ff};
                  qt = {qt[NUM_W-2:0], 1'b1};
               end else begin
                  qt = {qt[NUM_W-2:0], 1'b0};
               end
               r = trial[Q_W-1:0];
            end
            rem_in = r;
            num_in = n;
            quot_in = qt;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_CYC - 1)) begin
               state_in = LANE_FIN;
            end
         end
         LANE_FIN: begin
            if (neg_ff) begin
               if (quot_ff > NUM_W'(48'h8000_0000)) begin
                  val_in = Q_MIN;
                  sat_in = 1'b1;
               end else begin
                  val_in = Q_W'(-quot_ff[Q_W-1:0]);
               end
            end else begin
               if (quot_ff > NUM_W'(48'h7FFF_FFFF)) begin
                  val_in = Q_MAX;
                  sat_in = 1'b1;
               end else begin
                  val_in = quot_ff[Q_W-1:0];
               end
            end
            done_in = 1'b1;
            state_in = LANE_IDLE;
         end
         default: state_in = LANE_IDLE;
      endcase
   end

   assign lane_out.done = done_ff;
   assign lane_out.sat = sat_ff;
   assign lane_out.value = val_ff;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the 3x3 Jacobi solver unit with a fixed-point predictor.
module testbench;
   import jsu_pkg::*;

   typedef struct packed {
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic signed [31:0] z_value;
      logic               zero_diagonal;
      logic               saturated;
   } solution_type;

   typedef struct {
      logic [383:0] coefs;
      logic         known;
      solution_type answer;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [383:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;

   solution_type pending_solutions[$];
   stim_row_type directed_rows[$];
   int           mismatch_count = 0;
   bit           stimulus_done = 0;

   jacobi_3x3_linear_solver_unit u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200000000;
      $display("tb: failure");
      $finish;
   end

   function automatic longint clamp_q(longint v, ref bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint fixed_product(longint a, longint b, ref bit sat);
      longint p;
      p = a * b;
      return clamp_q(p >>> 16, sat);
   endfunction

   function automatic longint lane_update(longint rhs, longint c1, longint e1, longint c2,
                                          longint e2, longint diag, ref bit sat);
      longint s;
      s = rhs - fixed_product(c1, e1, sat) - fixed_product(c2, e2, sat);
      s = clamp_q(s, sat);
      return clamp_q((s * 65536) / diag, sat);
   endfunction

   function automatic solution_type solve_system(logic [383:0] coefs);
      longint       c[12];
      longint       x, y, z, nx, ny, nz;
      bit           sat;
      solution_type r;
      sat = 0;
      x = 0;
      y = 0;
      z = 0;
      for (int i = 0; i < 12; i++) c[i] = longint'($signed(coefs[i*32 +: 32]));
      r = '0;
      if (c[0] == 0 || c[5] == 0 || c[10] == 0) begin
         r.zero_diagonal = 1;
         return r;
      end
      for (int k = 0; k < SWEEPS; k++) begin
         nx = lane_update(c[3], c[1], y, c[2], z, c[0], sat);
         ny = lane_update(c[7], c[4], x, c[6], z, c[5], sat);
         nz = lane_update(c[11], c[8], x, c[9], y, c[10], sat);
         x = nx;
         y = ny;
         z = nz;
      end
      r.x_value = x[31:0];
      r.y_value = y[31:0];
      r.z_value = z[31:0];
      r.saturated = sat;
      return r;
   endfunction

   function automatic logic [383:0] pack_system(logic [31:0] v[12]);
      logic [383:0] d;
      for (int i = 0; i < 12; i++) d[i*32 +: 32] = v[i];
      return d;
   endfunction

   function automatic logic [31:0] random_coef(int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 262144)) - 131072);
         default: return 32'($signed($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   // Diagonally dominant systems converge, so most items exercise the normal path.
   function automatic logic [383:0] random_system();
      logic [31:0] v[12];
      int          mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 12; i++)
         v[i] = random_coef(mode < 2 ? 0 : (mode < 5 ? 1 : 2));
      if (mode >= 2) begin
         v[0] = 32'($signed($urandom_range(0, 1) ? 1 : -1) * $signed($urandom_range(300000, 2000000)));
         v[5] = 32'($signed($urandom_range(0, 1) ? 1 : -1) * $signed($urandom_range(300000, 2000000)));
         v[10] = 32'($signed($urandom_range(0, 1) ? 1 : -1) * $signed($urandom_range(300000, 2000000)));
         v[3] = $urandom;
         v[7] = $urandom;
         v[11] = $urandom;
      end
      if ($urandom_range(0, 39) == 0) v[5 * $urandom_range(0, 2)] = 0;
      return pack_system(v);
   endfunction

   task automatic add_row(logic [31:0] v[12], logic known, solution_type answer);
      stim_row_type row;
      row.coefs = pack_system(v);
      row.known = known;
      row.answer = answer;
      directed_rows.push_back(row);
   endtask

   task automatic send_system(logic [383:0] coefs);
      req_tvalid <= 1;
      req_tdata <= coefs;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      logic [31:0]  v[12];
      solution_type expected;
      int           burst;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (4) @(posedge clock);
      reset <= 0;

      expected = '0;
      expected.zero_diagonal = 1;
      for (int i = 0; i < 12; i++) v[i] = 32'hFFFF_FFFF;
      v[0] = 0;
      add_row(v, 1, expected);
      for (int i = 0; i < 12; i++) v[i] = 32'h8000_0000;
      v[5] = 0;
      add_row(v, 1, expected);
      for (int i = 0; i < 12; i++) v[i] = 32'h7FFF_FFFF;
      v[10] = 0;
      add_row(v, 1, expected);
      for (int i = 0; i < 12; i++) v[i] = 0;
      add_row(v, 1, expected);
      expected = '0;
      for (int i = 0; i < 12; i++) v[i] = 0;
      v[0] = 32'h0001_0000;
      v[5] = 32'h0001_0000;
      v[10] = 32'h0001_0000;
      add_row(v, 1, expected);
      v[3] = 32'h0002_0000;
      v[7] = 32'hFFFD_0000;
      v[11] = 32'h0000_8000;
      expected.x_value = 32'h0002_0000;
      expected.y_value = 32'hFFFD_0000;
      expected.z_value = 32'h0000_8000;
      add_row(v, 1, expected);
      for (int i = 0; i < 12; i++) v[i] = 32'h7FFF_FFFF;
      add_row(v, 0, expected);
      for (int i = 0; i < 12; i++) v[i] = 32'h8000_0000;
      add_row(v, 0, expected);
      for (int i = 0; i < 12; i++) v[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      add_row(v, 0, expected);
      for (int i = 0; i < 12; i++) v[i] = 32'h0000_0001;
      add_row(v, 0, expected);
      for (int i = 0; i < 12; i++) v[i] = 32'hFFFF_FFFF;
      add_row(v, 0, expected);
      for (int i = 0; i < 12; i++) v[i] = 32'h5555_5555 ^ (i[0] ? 32'hFFFF_FFFF : 0);
      add_row(v, 0, expected);
      for (int i = 0; i < 12; i++) v[i] = 32'h0000_4000;
      v[3] = 32'h7FFF_FFFF;
      add_row(v, 0, expected);
      for (int i = 0; i < 12; i++) v[i] = 32'h0001_0000;
      v[0] = 32'h0004_0000;
      v[5] = 32'hFFFC_0000;
      v[10] = 32'h0004_0000;
      v[7] = 32'h8000_0000;
      add_row(v, 0, expected);

      foreach (directed_rows[i]) begin
         pending_solutions.push_back(directed_rows[i].known ?
                                     directed_rows[i].answer : solve_system(directed_rows[i].coefs));
         send_system(directed_rows[i].coefs);
         if ($urandom_range(0, 2) == 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end

      for (int n = 0; n < 1840; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && n < 1840; b++, n++) begin
            begin
               logic [383:0] sys;
               sys = random_system();
               pending_solutions.push_back(solve_system(sys));
               send_system(sys);
            end
         end
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 250)) @(posedge clock);
         end
      end
      req_tvalid <= 0;
      stimulus_done = 1;
   end

   initial begin
      rsp_tready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         case ($urandom_range(0, 3))
            0: rsp_tready <= 1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      solution_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.x_value = rsp_tdata[31:0];
         got.y_value = rsp_tdata[63:32];
         got.z_value = rsp_tdata[95:64];
         got.zero_diagonal = rsp_tuser[0];
         got.saturated = rsp_tuser[1];
         if (pending_solutions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result item %h %b", rsp_tdata, rsp_tuser);
         end else begin
            want = pending_solutions.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected x=%h y=%h z=%h zd=%b sat=%b, got x=%h y=%h z=%h zd=%b sat=%b",
                           want.x_value, want.y_value, want.z_value, want.zero_diagonal,
                           want.saturated, got.x_value, got.y_value, got.z_value,
                           got.zero_diagonal, got.saturated);
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (pending_solutions.size() == 0);
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && pending_solutions.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

// ===== files.f =====
src/jsu_pkg.sv
src/jsu_lane.sv
src/jacobi_3x3_linear_solver_unit.sv
test/testbench.sv
